// ----- hdl/set_assoc_cache_lru_writeback_macros.svh -----
// Assertion macros used by the checker of the cache controller.
`ifndef SET_ASSOC_CACHE_LRU_WRITEBACK_MACROS_SVH
`define SET_ASSOC_CACHE_LRU_WRITEBACK_MACROS_SVH

// Same-cycle implication, sampled at clk, off during reset.
`define SACL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cache controller assertion failed");

// Next-cycle implication, sampled at clk, off during reset.
`define SACL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cache controller assertion failed");

`endif

// ----- hdl/sacl_pkg.sv -----
// Shared constants and types of the set-associative cache controller.
package sacl_pkg;

  localparam int ADDR_BITS   = 32;
  localparam int OFFSET_BITS = 3;
  localparam int INDEX_BITS  = 4;
  localparam int SETS        = 16;   // power of two, at most 2**INDEX_BITS
  localparam int WAYS        = 8;
  localparam int TAG_BITS    = ADDR_BITS - OFFSET_BITS - INDEX_BITS;
  localparam int SET_BITS    = $clog2(SETS);
  localparam int WAY_BITS    = $clog2(WAYS);
  localparam int RANK_BITS   = $clog2(WAYS);
  localparam int WAY_OUT_BITS = 3;
  localparam int STAT_BITS   = 32;

  localparam logic [RANK_BITS-1:0] RANK_OLDEST = RANK_BITS'(WAYS - 1);
  localparam logic [STAT_BITS-1:0] STAT_MAX    = '1;

  localparam logic OP_READ  = 1'b1;
  localparam logic OP_WRITE = 1'b0;

  localparam int NUM_STATS       = 7;
  localparam int STAT_READS      = 0;
  localparam int STAT_WRITES     = 1;
  localparam int STAT_READ_HITS  = 2;
  localparam int STAT_WRITE_HITS = 3;
  localparam int STAT_READ_MISS  = 4;
  localparam int STAT_WRITE_MISS = 5;
  localparam int STAT_WRITEBACKS = 6;

  typedef struct packed {
    logic [TAG_BITS-1:0]  tag;
    logic                 valid;
    logic                 dirty;
    logic [RANK_BITS-1:0] rank;
  } line_t;

  typedef line_t [WAYS-1:0] row_t;

  typedef struct packed {
    logic                hit;
    logic                writeback;
    logic [WAY_BITS-1:0] way;
  } lookup_t;

endpackage

// ----- hdl/sacl_channels.sv -----
// Valid/ready channel interfaces of the cache controller.
interface sacl_in_if;
  logic                             valid;
  logic                             ready;
  logic                             operation;
  logic [sacl_pkg::ADDR_BITS-1:0]   address;

  modport source (output valid, operation, address, input ready);
  modport sink   (input valid, operation, address, output ready);
endinterface

interface sacl_out_if;
  logic                                valid;
  logic                                ready;
  logic                                hit;
  logic                                writeback_needed;
  logic [sacl_pkg::WAY_OUT_BITS-1:0]   way_used;
  logic [sacl_pkg::STAT_BITS-1:0]      read_count;
  logic [sacl_pkg::STAT_BITS-1:0]      write_count;
  logic [sacl_pkg::STAT_BITS-1:0]      read_hits;
  logic [sacl_pkg::STAT_BITS-1:0]      write_hit_count;
  logic [sacl_pkg::STAT_BITS-1:0]      read_misses;
  logic [sacl_pkg::STAT_BITS-1:0]      write_miss_count;
  logic [sacl_pkg::STAT_BITS-1:0]      writebacks;

  modport source (output valid, hit, writeback_needed, way_used, read_count, write_count,
                  read_hits, write_hit_count, read_misses, write_miss_count, writebacks,
                  input ready);
  modport sink   (input valid, hit, writeback_needed, way_used, read_count, write_count,
                  read_hits, write_hit_count, read_misses, write_miss_count, writebacks,
                  output ready);
endinterface

// ----- hdl/set_assoc_cache_lru_writeback.sv -----
// Top level of the 8-way write-back, write-allocate cache tag controller.
// Input channel in_ch carries one access word: operation (1 read, 0 write) and
// a 32-bit byte address. Output channel out_ch returns one result word per
// access: hit, writeback_needed, way_used and the seven saturating counters as
// they stand after that access.
// Each set's tags, valid/dirty bits and LRU ranks sit in one row of a
// synchronous RAM (one row per set, registered read). An access is read
// on accept and written back when the lookup completes, so the block takes
// one access at a time; the read/modify/write of the set row sets the pace.
// The next access is read only after the write-back, so back-to-back hits on
// one set see fresh state.
// A finished result waits in the output register while a new access is read;
// if the receiver still stalls, the lookup holds until the register frees.
// Reset (rst_n low, synchronous) clears the counters, the output valid and a
// per-set row-valid flag; a row never written reads as all zero, so no
// clearing pass is needed and the block is ready right after reset.
module set_assoc_cache_lru_writeback (
  input  logic              clk,
  input  logic              rst_n,
  sacl_in_if.sink           in_ch,
  sacl_out_if.source        out_ch
);

  typedef enum logic {ST_IDLE, ST_LOOK} state_t;

  state_t                                              state_r;
  logic                                                out_valid_r;
  logic [sacl_pkg::SETS-1:0]                           row_init_r;
  logic [sacl_pkg::NUM_STATS-1:0][sacl_pkg::STAT_BITS-1:0] cnt_r;
  logic [sacl_pkg::NUM_STATS-1:0][sacl_pkg::STAT_BITS-1:0] cnt_nxt;
  sacl_pkg::lookup_t                                   res_r;
  logic [sacl_pkg::SET_BITS-1:0]                       set_r;
  logic [sacl_pkg::TAG_BITS-1:0]                       tag_r;
  logic                                                is_read_r;
  logic                                                row_ok_r;
  sacl_pkg::row_t                                      rd_row_r;

  sacl_pkg::row_t                 mem [sacl_pkg::SETS];
  sacl_pkg::row_t                 row_cur;
  sacl_pkg::row_t                 row_new;
  sacl_pkg::lookup_t              res;
  logic [sacl_pkg::SET_BITS-1:0]  in_set;
  logic                           in_acc;
  logic                           finish;

  function automatic logic [sacl_pkg::STAT_BITS-1:0] sat_inc(
    input logic [sacl_pkg::STAT_BITS-1:0] c);
    return (c == sacl_pkg::STAT_MAX) ? c : c + 1'b1;
  endfunction

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_set      = in_ch.address[sacl_pkg::OFFSET_BITS +: sacl_pkg::SET_BITS];
  // drain or empty output register lets the lookup complete
  assign finish      = (state_r == ST_LOOK) && (!out_valid_r || out_ch.ready);
  assign row_cur     = row_ok_r ? rd_row_r : '0;

  sacl_set_update u_upd (
    .row     (row_cur),
    .tag     (tag_r),
    .is_read (is_read_r),
    .row_new (row_new),
    .res     (res)
  );

  always_comb begin
    cnt_nxt = cnt_r;
    if (is_read_r == sacl_pkg::OP_READ) begin
      cnt_nxt[sacl_pkg::STAT_READS] = sat_inc(cnt_r[sacl_pkg::STAT_READS]);
      if (res.hit) begin
        cnt_nxt[sacl_pkg::STAT_READ_HITS] = sat_inc(cnt_r[sacl_pkg::STAT_READ_HITS]);
      end else begin
        cnt_nxt[sacl_pkg::STAT_READ_MISS] = sat_inc(cnt_r[sacl_pkg::STAT_READ_MISS]);
      end
    end else begin
      cnt_nxt[sacl_pkg::STAT_WRITES] = sat_inc(cnt_r[sacl_pkg::STAT_WRITES]);
      if (res.hit) begin
        cnt_nxt[sacl_pkg::STAT_WRITE_HITS] = sat_inc(cnt_r[sacl_pkg::STAT_WRITE_HITS]);
      end else begin
        cnt_nxt[sacl_pkg::STAT_WRITE_MISS] = sat_inc(cnt_r[sacl_pkg::STAT_WRITE_MISS]);
      end
    end
    if (res.writeback) begin
      cnt_nxt[sacl_pkg::STAT_WRITEBACKS] = sat_inc(cnt_r[sacl_pkg::STAT_WRITEBACKS]);
    end
  end

  // set RAM: read on accept, write back when the lookup completes
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_row_r <= mem[in_set];
    end
    if (finish) begin
      mem[set_r] <= row_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      row_init_r  <= '0;
      cnt_r       <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            state_r <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (finish) begin
            state_r           <= ST_IDLE;
            row_init_r[set_r] <= 1'b1;
            cnt_r             <= cnt_nxt;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    // payload, no reset
    if (in_acc) begin
      set_r     <= in_set;
      tag_r     <= in_ch.address[sacl_pkg::ADDR_BITS-1 -: sacl_pkg::TAG_BITS];
      is_read_r <= in_ch.operation;
      row_ok_r  <= row_init_r[in_set];
    end
    if (finish) begin
      res_r <= res;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.hit              = res_r.hit;
  assign out_ch.writeback_needed = res_r.writeback;
  assign out_ch.way_used         = sacl_pkg::WAY_OUT_BITS'(res_r.way);
  assign out_ch.read_count       = cnt_r[sacl_pkg::STAT_READS];
  assign out_ch.write_count      = cnt_r[sacl_pkg::STAT_WRITES];
  assign out_ch.read_hits        = cnt_r[sacl_pkg::STAT_READ_HITS];
  assign out_ch.write_hit_count  = cnt_r[sacl_pkg::STAT_WRITE_HITS];
  assign out_ch.read_misses      = cnt_r[sacl_pkg::STAT_READ_MISS];
  assign out_ch.write_miss_count = cnt_r[sacl_pkg::STAT_WRITE_MISS];
  assign out_ch.writebacks       = cnt_r[sacl_pkg::STAT_WRITEBACKS];

endmodule

// ----- hdl/sacl_set_update.sv -----
// Lookup, victim choice and LRU/tag/dirty update of one set row.
module sacl_set_update (
  input  sacl_pkg::row_t                   row,
  input  logic [sacl_pkg::TAG_BITS-1:0]    tag,
  input  logic                             is_read,
  output sacl_pkg::row_t                   row_new,
  output sacl_pkg::lookup_t                res
);

  logic [sacl_pkg::WAYS-1:0]      hit_vec;
  logic [sacl_pkg::WAYS-1:0]      free_vec;
  logic [sacl_pkg::WAYS-1:0]      old_vec;
  logic [sacl_pkg::WAY_BITS-1:0]  hit_way;
  logic [sacl_pkg::WAY_BITS-1:0]  free_way;
  logic [sacl_pkg::WAY_BITS-1:0]  old_way;
  logic [sacl_pkg::WAY_BITS-1:0]  way;
  logic                           hit;
  logic                           found;
  logic                           was_valid;
  logic [sacl_pkg::RANK_BITS-1:0] old_rank;

  always_comb begin
    for (int i = 0; i < sacl_pkg::WAYS; i++) begin
      hit_vec[i]  = row[i].valid && (row[i].tag == tag);
      free_vec[i] = !row[i].valid;
      old_vec[i]  = (row[i].rank == sacl_pkg::RANK_OLDEST);
    end
    // scan downward so the lowest-numbered way wins
    hit_way  = '0;
    free_way = '0;
    old_way  = '0;
    for (int i = sacl_pkg::WAYS - 1; i >= 0; i--) begin
      if (hit_vec[i])  hit_way  = sacl_pkg::WAY_BITS'(i);
      if (free_vec[i]) free_way = sacl_pkg::WAY_BITS'(i);
      if (old_vec[i])  old_way  = sacl_pkg::WAY_BITS'(i);
    end
    hit   = |hit_vec;
    found = |free_vec;
    // ranks of a full set form a permutation, so the oldest way is the victim
    way       = hit ? hit_way : (found ? free_way : old_way);
    was_valid = hit || !found;
    old_rank  = row[way].rank;

    res.hit       = hit;
    res.writeback = !hit && !found && row[way].dirty;
    res.way       = way;

    for (int i = 0; i < sacl_pkg::WAYS; i++) begin
      row_new[i] = row[i];
      if (way == sacl_pkg::WAY_BITS'(i)) begin
        row_new[i].rank = '0;
        if (hit) begin
          row_new[i].dirty = row[i].dirty || !is_read;
        end else begin
          row_new[i].valid = 1'b1;
          row_new[i].tag   = tag;
          row_new[i].dirty = !is_read;
        end
      end else if (row[i].valid && (!was_valid || row[i].rank < old_rank)
                   && row[i].rank != sacl_pkg::RANK_OLDEST) begin
        row_new[i].rank = row[i].rank + 1'b1;
      end
    end
  end

endmodule

// ----- hdl/sacl_checker.sv -----
// Port-level checker of the cache controller, bound to the top level.
`include "set_assoc_cache_lru_writeback_macros.svh"

module sacl_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic                                  out_hit,
  input logic                                  out_wb,
  input logic [sacl_pkg::WAY_OUT_BITS-1:0]     out_way,
  input logic [sacl_pkg::STAT_BITS-1:0]        out_writebacks
);

  // one access at a time: a taken word blocks the next cycle
  `SACL_ASSERT_NEXT(a_one_access, in_valid && in_ready, !in_ready)

  // a hit never evicts
  `SACL_ASSERT_NOW(a_hit_no_wb, out_valid && out_hit, !out_wb)

  // an eviction is always counted
  `SACL_ASSERT_NOW(a_wb_counted, out_valid && out_wb, out_writebacks != '0)

  // a stalled result word holds
  `SACL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_way))

endmodule

bind set_assoc_cache_lru_writeback sacl_checker u_sacl_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_hit        (out_ch.hit),
  .out_wb         (out_ch.writeback_needed),
  .out_way        (out_ch.way_used),
  .out_writebacks (out_ch.writebacks)
);

// ----- tb/cache_lookup_checker.sv -----
// Watches both cache channels, predicts each lookup result and compares it.
`timescale 1ns / 100ps

module cache_lookup_checker (
  input  logic      clk,
  input  logic      rst_n,
  sacl_in_if        in_ch,
  sacl_out_if       out_ch,
  output int        mismatches,
  output int        awaiting
);

  typedef struct packed {
    logic                                                    hit;
    logic                                                    writeback;
    logic [sacl_pkg::WAY_OUT_BITS-1:0]                       way;
    logic [sacl_pkg::NUM_STATS-1:0][sacl_pkg::STAT_BITS-1:0] counts;
  } lookup_outcome_t;

  // Shadow copy of the tag store, one entry per set and way.
  logic [sacl_pkg::TAG_BITS-1:0]  shadow_tag   [sacl_pkg::SETS][sacl_pkg::WAYS];
  bit                             shadow_valid [sacl_pkg::SETS][sacl_pkg::WAYS];
  bit                             shadow_dirty [sacl_pkg::SETS][sacl_pkg::WAYS];
  logic [sacl_pkg::RANK_BITS-1:0] shadow_age   [sacl_pkg::SETS][sacl_pkg::WAYS];
  logic [sacl_pkg::STAT_BITS-1:0] shadow_stats [sacl_pkg::NUM_STATS];

  lookup_outcome_t expected_lookups[$];
  lookup_outcome_t want;
  logic [sacl_pkg::NUM_STATS-1:0][sacl_pkg::STAT_BITS-1:0] seen_counts;
  int error_total;

  string stat_label [sacl_pkg::NUM_STATS] = '{"read_count", "write_count", "read_hits",
                                              "write_hit_count", "read_misses",
                                              "write_miss_count", "writebacks"};

  function automatic void count_up(int k);
    if (shadow_stats[k] != sacl_pkg::STAT_MAX) shadow_stats[k]++;
  endfunction

  // Make a way most recent; valid ways that were younger (or all, on a fill) age by one.
  function automatic void promote(int row, int w, bit was_valid);
    logic [sacl_pkg::RANK_BITS-1:0] prior;
    prior = shadow_age[row][w];
    for (int i = 0; i < sacl_pkg::WAYS; i++) begin
      if (i != w && shadow_valid[row][i] && (!was_valid || shadow_age[row][i] < prior) &&
          shadow_age[row][i] < sacl_pkg::RANK_OLDEST) begin
        shadow_age[row][i]++;
      end
    end
    shadow_age[row][w] = '0;
  endfunction

  function automatic lookup_outcome_t predict_lookup(logic op,
                                                     logic [sacl_pkg::ADDR_BITS-1:0] addr);
    lookup_outcome_t r;
    logic [sacl_pkg::TAG_BITS-1:0] tag;
    bit is_read, hit, found, wb;
    int row, way, oldest;
    is_read = (op == sacl_pkg::OP_READ);
    row = int'(addr[sacl_pkg::OFFSET_BITS +: sacl_pkg::INDEX_BITS]) % sacl_pkg::SETS;
    tag = addr[sacl_pkg::ADDR_BITS-1 -: sacl_pkg::TAG_BITS];
    hit = 1'b0;
    found = 1'b0;
    wb = 1'b0;
    way = 0;
    count_up(is_read ? sacl_pkg::STAT_READS : sacl_pkg::STAT_WRITES);
    for (int w = 0; w < sacl_pkg::WAYS; w++) begin
      if (!hit && shadow_valid[row][w] && shadow_tag[row][w] == tag) begin
        hit = 1'b1;
        way = w;
      end
    end
    if (hit) begin
      count_up(is_read ? sacl_pkg::STAT_READ_HITS : sacl_pkg::STAT_WRITE_HITS);
      promote(row, way, 1'b1);
      if (!is_read) shadow_dirty[row][way] = 1'b1;
    end else begin
      count_up(is_read ? sacl_pkg::STAT_READ_MISS : sacl_pkg::STAT_WRITE_MISS);
      for (int w = 0; w < sacl_pkg::WAYS; w++) begin
        if (!found && !shadow_valid[row][w]) begin
          found = 1'b1;
          way = w;
        end
      end
      if (found) begin
        promote(row, way, 1'b0);
      end else begin
        // Full set: evict the oldest, lowest way on a tie.
        oldest = 0;
        for (int w = 1; w < sacl_pkg::WAYS; w++) begin
          if (shadow_age[row][w] > shadow_age[row][oldest]) oldest = w;
        end
        way = oldest;
        if (shadow_dirty[row][way]) begin
          wb = 1'b1;
          count_up(sacl_pkg::STAT_WRITEBACKS);
        end
        promote(row, way, 1'b1);
      end
      shadow_valid[row][way] = 1'b1;
      shadow_tag[row][way] = tag;
      shadow_dirty[row][way] = !is_read;
    end
    r.hit = hit;
    r.writeback = wb;
    r.way = sacl_pkg::WAY_OUT_BITS'(way);
    for (int k = 0; k < sacl_pkg::NUM_STATS; k++) r.counts[k] = shadow_stats[k];
    return r;
  endfunction

  function automatic void check_field(string label, logic [sacl_pkg::STAT_BITS-1:0] exp_val,
                                      logic [sacl_pkg::STAT_BITS-1:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0h, got %0h", label, exp_val, act_val);
      error_total++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < sacl_pkg::SETS; s++) begin
        for (int w = 0; w < sacl_pkg::WAYS; w++) begin
          shadow_tag[s][w] = '0;
          shadow_valid[s][w] = 1'b0;
          shadow_dirty[s][w] = 1'b0;
          shadow_age[s][w] = '0;
        end
      end
      for (int k = 0; k < sacl_pkg::NUM_STATS; k++) shadow_stats[k] = '0;
      expected_lookups.delete();
    end else begin
      // Retire first: a result can never belong to the word accepted at the same edge.
      if (out_ch.valid && out_ch.ready) begin
        if (expected_lookups.size() == 0) begin
          $error("result word with no pending access");
          error_total++;
        end else begin
          want = expected_lookups.pop_front();
          seen_counts = {out_ch.writebacks, out_ch.write_miss_count, out_ch.read_misses,
                         out_ch.write_hit_count, out_ch.read_hits, out_ch.write_count,
                         out_ch.read_count};
          check_field("hit", sacl_pkg::STAT_BITS'(want.hit),
                      sacl_pkg::STAT_BITS'(out_ch.hit));
          check_field("writeback_needed", sacl_pkg::STAT_BITS'(want.writeback),
                      sacl_pkg::STAT_BITS'(out_ch.writeback_needed));
          check_field("way_used", sacl_pkg::STAT_BITS'(want.way),
                      sacl_pkg::STAT_BITS'(out_ch.way_used));
          for (int k = 0; k < sacl_pkg::NUM_STATS; k++) begin
            check_field(stat_label[k], want.counts[k], seen_counts[k]);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_lookups.push_back(predict_lookup(in_ch.operation, in_ch.address));
      end
    end
    mismatches <= error_total;
    awaiting <= expected_lookups.size();
  end

endmodule

// ----- tb/testbench.sv -----
// Top of the cache controller testbench: clock, reset, access stimulus and verdict.
`timescale 1ns / 100ps

module testbench;

  localparam int RANDOM_ACCESSES = 450;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int LONG_HOLD       = 64;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   awaiting;
  int   cycle_count;
  bit   hold_long;
  bit   tail_phase;

  sacl_in_if  in_ch ();
  sacl_out_if out_ch ();

  set_assoc_cache_lru_writeback dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  cache_lookup_checker lookup_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic logic [sacl_pkg::ADDR_BITS-1:0] make_address(
    logic [sacl_pkg::TAG_BITS-1:0] tag, int row, int offs);
    return {tag, sacl_pkg::INDEX_BITS'(row), sacl_pkg::OFFSET_BITS'(offs)};
  endfunction

  // Offer one access word and hold it until accepted; valid stays high for the next word.
  task automatic push_access(logic op, logic [sacl_pkg::ADDR_BITS-1:0] addr);
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.address <= addr;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (awaiting == 0);
    @(posedge clk);
  endtask

  // Result sink: short random stalls, one long hold-off on request, none in the tail.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        hold_long = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [sacl_pkg::TAG_BITS-1:0] tag_pool [12];
    int hot_rows [4];
    logic [sacl_pkg::ADDR_BITS-1:0] addr;
    int row;
    hold_long = 1'b0;
    tail_phase = 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.operation <= sacl_pkg::OP_READ;
    in_ch.address <= '0;
    rst_n <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Address extremes, offset-only differences, write hit on a clean line.
    push_access(sacl_pkg::OP_READ, 32'h0000_0000);
    push_access(sacl_pkg::OP_WRITE, 32'hFFFF_FFFF);
    push_access(sacl_pkg::OP_READ, 32'hFFFF_FFF8);
    push_access(sacl_pkg::OP_WRITE, 32'h0000_0007);
    // Fill one set, alternating dirty and clean lines.
    for (int k = 1; k <= sacl_pkg::WAYS; k++) begin
      push_access((k % 2) ? sacl_pkg::OP_WRITE : sacl_pkg::OP_READ,
                  make_address(sacl_pkg::TAG_BITS'(k), 5, k));
    end
    push_access(sacl_pkg::OP_READ, make_address(sacl_pkg::TAG_BITS'(1), 5, 0));
    push_access(sacl_pkg::OP_READ, make_address(sacl_pkg::TAG_BITS'(9), 5, 0));
    push_access(sacl_pkg::OP_WRITE, make_address(sacl_pkg::TAG_BITS'(10), 5, 3));
    push_access(sacl_pkg::OP_WRITE, make_address(sacl_pkg::TAG_BITS'(4), 5, 1));
    push_access(sacl_pkg::OP_READ, make_address(sacl_pkg::TAG_BITS'(11), 5, 2));
    push_access(sacl_pkg::OP_WRITE, make_address('1, 5, 7));
    push_access(sacl_pkg::OP_READ, make_address(sacl_pkg::TAG_BITS'(2), 5, 0));
    push_access(sacl_pkg::OP_READ, make_address('1, 5, 4));

    for (int k = 0; k < 12; k++) tag_pool[k] = sacl_pkg::TAG_BITS'($urandom);
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int k = 0; k < 4; k++) hot_rows[k] = $urandom_range(0, sacl_pkg::SETS - 1);

    for (int n = 0; n < RANDOM_ACCESSES; n++) begin
      if (n == 150) hold_long = 1'b1;
      if (n == 300) drain_results();
      if (n == 390) tail_phase = 1'b1;
      if (!tail_phase && (n / 40) % 3 != 2 && $urandom_range(0, 4) == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      if ($urandom_range(0, 6) == 0) begin
        addr = $urandom;
      end else begin
        row = ($urandom_range(0, 3) == 0) ? $urandom_range(0, sacl_pkg::SETS - 1)
                                          : hot_rows[$urandom_range(0, 3)];
        addr = make_address(tag_pool[$urandom_range(0, 11)], row, $urandom_range(0, 7));
      end
      push_access($urandom_range(0, 1) ? sacl_pkg::OP_READ : sacl_pkg::OP_WRITE, addr);
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && awaiting == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/sacl_pkg.sv
hdl/sacl_channels.sv
hdl/sacl_set_update.sv
hdl/set_assoc_cache_lru_writeback.sv
hdl/sacl_checker.sv
tb/cache_lookup_checker.sv
tb/testbench.sv
